// ===== hdl/bcsv_pkg.sv =====
// shared types and constants for the braced csv integer frame parser
// no dependencies; imported by the channel interfaces and every module
package bcsv_pkg;

   localparam int unsigned VAL_W      = 32;
   localparam int unsigned OUT_FIELDS = 4;

   // characters
   localparam logic [7:0] CHR_LBRACE = 8'h7B;
   localparam logic [7:0] CHR_RBRACE = 8'h7D;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;
   localparam logic [7:0] CHR_PLUS   = 8'h2B;
   localparam logic [7:0] CHR_MINUS  = 8'h2D;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_CR     = 8'h0D;

   // number parse phases
   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_STOP   = 2'd2;

   localparam logic [VAL_W-1:0] MAG_CAP = 32'h8000_0000;
   localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [VAL_W-1:0] acc;   // magnitude, never above MAG_CAP
      logic [1:0]       phase;
      logic             neg;
   } num_state_type;

   localparam num_state_type NUM_CLEAR = '{acc: '0, phase: PH_LEAD, neg: 1'b0};

endpackage

// ===== hdl/bcsv_chan_if.sv =====
// valid/ready channel interfaces for the request and response words
// depends on bcsv_pkg
interface bcsv_req_if;
   import bcsv_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       buffer_end;
   modport source (output valid, rx_byte, buffer_end, input ready);
   modport sink   (input valid, rx_byte, buffer_end, output ready);
endinterface

interface bcsv_rsp_if;
   import bcsv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] right_encoder;
   logic signed [VAL_W-1:0] left_encoder;
   logic signed [VAL_W-1:0] lift_position;
   logic signed [VAL_W-1:0] claw_position;
   logic                    frame_found;
   modport source (output valid, right_encoder, left_encoder, lift_position,
                   claw_position, frame_found, input ready);
   modport sink   (input valid, right_encoder, left_encoder, lift_position,
                   claw_position, frame_found, output ready);
endinterface

// ===== hdl/bcsv_num_step.sv =====
// one character step of the atoi style number parser, plus the saturated
// signed value of the field as it stands; depends on bcsv_pkg
module bcsv_num_step (
   input  bcsv_pkg::num_state_type cur,
   input  logic [7:0]              chr,
   output bcsv_pkg::num_state_type nxt,
   output logic [bcsv_pkg::VAL_W-1:0] field_val
);
   import bcsv_pkg::*;

   logic            is_digit;
   logic            is_blank;
   logic [VAL_W+3:0] acc10;

   assign is_digit = chr inside {[CHR_ZERO:CHR_NINE]};
   assign is_blank = (chr == CHR_SPACE) || (chr inside {[CHR_TAB:CHR_CR]});

   // acc * 10 + digit
   assign acc10 = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
                + {(VAL_W+4)'(chr[3:0])};

   always_comb begin
      logic take_digit;
      nxt        = cur;
      take_digit = 1'b0;
      case (cur.phase)
         PH_LEAD: begin
            if (is_blank) begin
               nxt = cur;
            end else if (chr == CHR_PLUS) begin
               nxt.phase = PH_DIGITS;
            end else if (chr == CHR_MINUS) begin
               nxt.phase = PH_DIGITS;
               nxt.neg   = 1'b1;
            end else begin
               take_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            take_digit = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase
      if (take_digit) begin
         if (is_digit) begin
            nxt.phase = PH_DIGITS;
            if (acc10 > {4'b0000, MAG_CAP}) begin
               nxt.acc = MAG_CAP;
            end else begin
               nxt.acc = acc10[VAL_W-1:0];
            end
         end else begin
            nxt.phase = PH_STOP;
         end
      end
   end

   // magnitude tops out at MAG_CAP, so bit 31 alone flags overflow when positive
   assign field_val = cur.neg     ? (VAL_W)'({VAL_W{1'b0}} - cur.acc) :
                      cur.acc[VAL_W-1] ? POS_MAX : cur.acc;

endmodule

// ===== hdl/braced_csv_integer_frame_parser.sv =====
// braced csv integer frame parser top level; depends on bcsv_pkg, bcsv_chan_if, bcsv_num_step
// one request word per cycle sustained, but for the stall below; each word passes the input register, and
// the response for a buffer_end word is then registered in the response register
// a buffer_end word stalls the input only while the response register is full and not taken
// synchronous active high reset clears held values to zero and all frame state but the staged and closed values
module braced_csv_integer_frame_parser #(
   parameter int unsigned FIELD_COUNT = 4
) (
   input  logic     clock,
   input  logic     reset,
   bcsv_req_if.sink   req_ch,
   bcsv_rsp_if.source rsp_ch
);
   import bcsv_pkg::*;

   localparam int unsigned PW = $clog2(FIELD_COUNT + 1);

   // input register
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       adv;

   // frame state
   logic [VAL_W-1:0]       staged_ff [FIELD_COUNT];
   logic [VAL_W-1:0]       staged_in [FIELD_COUNT];
   logic [VAL_W-1:0]       closed_ff [FIELD_COUNT];
   logic [VAL_W-1:0]       closed_in [FIELD_COUNT];
   logic [VAL_W-1:0]       held_ff   [FIELD_COUNT];
   logic [VAL_W-1:0]       held_in   [FIELD_COUNT];
   logic [FIELD_COUNT-1:0] mask_ff, mask_in;
   logic [FIELD_COUNT-1:0] closed_mask_ff, closed_mask_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic                   inside_ff, inside_in;
   logic                   after_comma_ff, after_comma_in;
   logic                   found_ff, found_in;
   num_state_type          num_ff, num_in, num_fed;
   logic [VAL_W-1:0]       field_val;
   logic                   finish;

   // response register
   logic             out_vld_ff;
   logic [VAL_W-1:0] out_val_ff [OUT_FIELDS];
   logic             out_found_ff;

   bcsv_num_step u_num (
      .cur       (num_ff),
      .chr       (in_byte_ff),
      .nxt       (num_fed),
      .field_val (field_val)
   );

   assign adv          = in_vld_ff && (!in_end_ff || !out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_vld_ff <= 1'b1;
      end else if (adv) begin
         in_vld_ff <= 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
         in_end_ff  <= req_ch.buffer_end;
      end
   end

   always_comb begin
      staged_in      = staged_ff;
      closed_in      = closed_ff;
      held_in        = held_ff;
      mask_in        = mask_ff;
      closed_mask_in = closed_mask_ff;
      pos_in         = pos_ff;
      inside_in      = inside_ff;
      after_comma_in = after_comma_ff;
      found_in       = found_ff;
      num_in         = num_ff;
      finish         = 1'b0;

      if (in_byte_ff == CHR_LBRACE) begin
         inside_in      = 1'b1;
         mask_in        = '0;
         pos_in         = '0;
         after_comma_in = 1'b1;
         num_in         = NUM_CLEAR;
      end else if (in_byte_ff == CHR_RBRACE) begin
         if (inside_ff) begin
            finish = !after_comma_ff;
         end
      end else if (inside_ff) begin
         if (in_byte_ff == CHR_COMMA) begin
            finish         = 1'b1;
            after_comma_in = 1'b1;
         end else begin
            after_comma_in = 1'b0;
            num_in         = num_fed;
         end
      end

      if (finish) begin
         for (int k = 0; k < FIELD_COUNT; k++) begin
            if (pos_ff == PW'(k)) begin
               staged_in[k] = field_val;
               mask_in[k]   = 1'b1;
            end
         end
         if (pos_ff < PW'(FIELD_COUNT)) begin
            pos_in = pos_ff + PW'(1);
         end
         num_in = NUM_CLEAR;
      end

      // closing brace snapshots the frame including the field it just ended
      if (in_byte_ff == CHR_RBRACE && inside_ff) begin
         closed_in      = staged_in;
         closed_mask_in = mask_in;
         found_in       = 1'b1;
         inside_in      = 1'b0;
      end

      if (in_end_ff) begin
         for (int k = 0; k < FIELD_COUNT; k++) begin
            if (closed_mask_in[k]) begin
               held_in[k] = closed_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= '0;
         closed_mask_ff <= '0;
         pos_ff         <= '0;
         inside_ff      <= 1'b0;
         after_comma_ff <= 1'b0;
         found_ff       <= 1'b0;
         num_ff         <= NUM_CLEAR;
         for (int k = 0; k < FIELD_COUNT; k++) begin
            held_ff[k] <= '0;
         end
      end else if (adv) begin
         held_ff <= held_in;
         if (in_end_ff) begin
            mask_ff        <= '0;
            closed_mask_ff <= '0;
            pos_ff         <= '0;
            inside_ff      <= 1'b0;
            after_comma_ff <= 1'b0;
            found_ff       <= 1'b0;
            num_ff         <= NUM_CLEAR;
         end else begin
            mask_ff        <= mask_in;
            closed_mask_ff <= closed_mask_in;
            pos_ff         <= pos_in;
            inside_ff      <= inside_in;
            after_comma_ff <= after_comma_in;
            found_ff       <= found_in;
            num_ff         <= num_in;
         end
      end
      if (adv) begin
         staged_ff <= staged_in;
         closed_ff <= closed_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv && in_end_ff) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_ff <= 1'b0;
      end
      if (adv && in_end_ff) begin
         for (int k = 0; k < OUT_FIELDS; k++) begin
            // slots beyond the field count are written with zero
            out_val_ff[k] <= (k < FIELD_COUNT) ? held_in[k] : '0;
         end
         out_found_ff <= found_in;
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.right_encoder = out_val_ff[0];
   assign rsp_ch.left_encoder  = out_val_ff[1];
   assign rsp_ch.lift_position = out_val_ff[2];
   assign rsp_ch.claw_position = out_val_ff[3];
   assign rsp_ch.frame_found   = out_found_ff;

   // staged fields always fill from slot zero upward
   a_mask_pos: assert property (@(posedge clock) disable iff (reset)
      $countones(mask_ff) == int'(pos_ff))
      else $error("staged mask does not match field position");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(FIELD_COUNT))
      else $error("field position beyond field count");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(adv && in_end_ff))
      else $error("response raised without a buffer end word");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      adv && in_end_ff |=> !inside_ff && !found_ff && mask_ff == '0)
      else $error("frame state not cleared after buffer end");

endmodule
